@@ rtl/core/bbi_pkg.sv @@
`default_nettype none
package bbi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = CNT_W;
  localparam int BP_W        = 32;
  localparam int STEP_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int WT_W        = FRAC_W + 1;
  localparam int VAL_W       = 32;

  localparam logic [WT_W-1:0] WEIGHT_ONE = WT_W'(1) << FRAC_W;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = WT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic [1:0] MODE_UNDEF   = 2'd0;
  localparam logic [1:0] MODE_CONST   = 2'd1;
  localparam logic [1:0] MODE_NEAREST = 2'd2;
  localparam logic [1:0] MODE_LINEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_EQUAL = 2'd2;
  localparam logic [1:0] ST_MODE  = 2'd3;

  localparam logic [1:0] RD_KEND = 2'd0;
  localparam logic [1:0] RD_ZERO = 2'd1;
  localparam logic [1:0] RD_MID  = 2'd2;

  localparam logic [2:0] RES_HOLD     = 3'd0;
  localparam logic [2:0] RES_WRITE    = 3'd1;
  localparam logic [2:0] RES_CLAMP_HI = 3'd2;
  localparam logic [2:0] RES_CLAMP_LO = 3'd3;
  localparam logic [2:0] RES_EQUAL    = 3'd4;
  localparam logic [2:0] RES_NEAREST  = 3'd5;
  localparam logic [2:0] RES_LINEAR   = 3'd6;
  localparam logic [2:0] RES_MODE     = 3'd7;

  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic [1:0] rd_sel;
    logic       load_hi;
    logic       load_lo;
    logic       bis_step;
    logic       div_init;
    logic       div_step;
    logic       mul_lo;
    logic [2:0] res_sel;
  } bbi_cmd_t;

  typedef struct packed {
    logic clamp_hi;
    logic clamp_lo;
    logic more;
    logic dx_zero;
    logic mode_near;
    logic mode_lin;
  } bbi_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/bbi_dp.sv @@
`default_nettype none
module bbi_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [bbi_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [bbi_pkg::BP_W-1:0]       in_entry_breakpoint,
  input  wire logic [bbi_pkg::STEP_W-1:0]     in_entry_step,
  input  wire logic [bbi_pkg::BP_W-1:0]       in_sample_point,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [bbi_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire bbi_pkg::bbi_cmd_t              cmd,
  output bbi_pkg::bbi_stat_t                  stat,
  output logic [1:0]                          out_status,
  output logic [bbi_pkg::IDX_W-1:0]           out_lower_index,
  output logic [bbi_pkg::IDX_W-1:0]           out_upper_index,
  output logic [bbi_pkg::WT_W-1:0]            out_weight_lower,
  output logic [bbi_pkg::WT_W-1:0]            out_weight_upper,
  output logic [bbi_pkg::CNT_W-1:0]           out_driver_step,
  output logic [bbi_pkg::VAL_W-1:0]           out_interp_step
);

  localparam int NUM_W = bbi_pkg::BP_W + bbi_pkg::FRAC_W;

  logic [1:0]                    mode_r;
  logic [bbi_pkg::CNT_W-1:0]     count_r;
  logic [bbi_pkg::IDX_W-1:0]     kend;
  logic [bbi_pkg::CNT_W-1:0]     count_m1;

  logic [bbi_pkg::IDX_W-1:0]     idx_r;
  logic [bbi_pkg::BP_W-1:0]      wbp_r;
  logic [bbi_pkg::STEP_W-1:0]    wstep_r;
  logic [bbi_pkg::BP_W-1:0]      x_r;

  logic [bbi_pkg::BP_W-1:0]      bp_mem [bbi_pkg::TABLE_DEPTH];
  logic [bbi_pkg::STEP_W-1:0]    st_mem [bbi_pkg::TABLE_DEPTH];
  logic [bbi_pkg::IDX_W-1:0]     rd_addr;
  logic [bbi_pkg::BP_W-1:0]      rd_bp_r;
  logic [bbi_pkg::STEP_W-1:0]    rd_st_r;

  logic [bbi_pkg::IDX_W-1:0]     lo_r, hi_r, mid_r, lo_n, hi_n, mid_n, span;
  logic [bbi_pkg::IDX_W:0]       mid_sum;
  logic                          probe_gt;
  logic [bbi_pkg::BP_W-1:0]      blo_r, bhi_r;
  logic [bbi_pkg::STEP_W-1:0]    slo_r, shi_r;

  logic [bbi_pkg::BP_W-1:0]      dx;
  logic [NUM_W-1:0]              num;
  logic [bbi_pkg::BP_W-1:0]      rem_r;
  logic [bbi_pkg::WT_W-1:0]      quo_r;
  logic [bbi_pkg::BP_W:0]        trial;
  logic                          trial_ge;
  logic [bbi_pkg::WT_W-1:0]      wu, wl;
  logic [bbi_pkg::BP_W:0]        prod_r;
  logic [bbi_pkg::BP_W:0]        lin_sum;
  logic [bbi_pkg::BP_W:0]        gap2;
  logic                          pick_hi;
  logic [bbi_pkg::IDX_W-1:0]     pick_idx;
  logic [bbi_pkg::STEP_W-1:0]    pick_step;

  logic [1:0]                    status_nxt;
  logic [bbi_pkg::IDX_W-1:0]     lower_nxt, upper_nxt;
  logic [bbi_pkg::WT_W-1:0]      wl_nxt, wu_nxt;
  logic [bbi_pkg::CNT_W-1:0]     drv_nxt;
  logic [bbi_pkg::VAL_W-1:0]     val_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bbi_pkg::MODE_LINEAR;
      count_r <= bbi_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bbi_pkg::CFG_MODE:  mode_r  <= cfg_wdata[1:0];
        bbi_pkg::CFG_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign count_m1 = count_r - bbi_pkg::CNT_W'(1);

  always_comb begin
    if (count_r == '0) begin
      kend = '0;
    end else if (count_r > bbi_pkg::CNT_W'(bbi_pkg::TABLE_DEPTH)) begin
      kend = bbi_pkg::IDX_W'(bbi_pkg::TABLE_DEPTH - 1);
    end else begin
      kend = count_m1[bbi_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= in_entry_index;
      wbp_r   <= in_entry_breakpoint;
      wstep_r <= in_entry_step;
      x_r     <= in_sample_point;
    end
  end

  // table memories, one address per cycle, registered read
  always_comb begin
    case (cmd.rd_sel)
      bbi_pkg::RD_KEND: rd_addr = kend;
      bbi_pkg::RD_ZERO: rd_addr = '0;
      bbi_pkg::RD_MID:  rd_addr = mid_n;
      default:          rd_addr = mid_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      bp_mem[idx_r] <= wbp_r;
      st_mem[idx_r] <= wstep_r;
    end
    rd_bp_r <= bp_mem[rd_addr];
    rd_st_r <= st_mem[rd_addr];
  end

  // bisection bracket
  assign probe_gt = rd_bp_r > x_r;

  always_comb begin
    lo_n = lo_r;
    hi_n = hi_r;
    if (cmd.load_lo) begin
      lo_n = '0;
    end
    if (cmd.bis_step) begin
      if (probe_gt) begin
        hi_n = mid_r;
      end else begin
        lo_n = mid_r;
      end
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n   = mid_sum[bbi_pkg::IDX_W:1];
    span    = hi_n - lo_n;
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_n;
    hi_r <= cmd.load_hi ? kend : hi_n;
    if (cmd.rd_sel == bbi_pkg::RD_MID) begin
      mid_r <= mid_n;
    end
    if (cmd.load_hi || (cmd.bis_step && probe_gt)) begin
      bhi_r <= rd_bp_r;
      shi_r <= rd_st_r;
    end
    if (cmd.load_lo || (cmd.bis_step && !probe_gt)) begin
      blo_r <= rd_bp_r;
      slo_r <= rd_st_r;
    end
  end

  assign dx = bhi_r - blo_r;

  // upper weight: round(((x - blo) << 16) / dx), quotient fits in 17 bits
  assign num      = {x_r - blo_r, bbi_pkg::FRAC_W'(0)} + NUM_W'(dx[bbi_pkg::BP_W-1:1]);
  assign trial    = {rem_r, quo_r[bbi_pkg::WT_W-1]};
  assign trial_ge = trial >= {1'b0, dx};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= bbi_pkg::BP_W'(num[NUM_W-1:bbi_pkg::WT_W]);
      quo_r <= num[bbi_pkg::WT_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? bbi_pkg::BP_W'(trial - {1'b0, dx}) : trial[bbi_pkg::BP_W-1:0];
      quo_r <= {quo_r[bbi_pkg::WT_W-2:0], trial_ge};
    end
  end

  assign wu = (quo_r > bbi_pkg::WEIGHT_ONE) ? bbi_pkg::WEIGHT_ONE : quo_r;
  assign wl = bbi_pkg::WEIGHT_ONE - wu;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod_r <= {(bbi_pkg::BP_W + 1 - bbi_pkg::WT_W)'(0), wl}
              * {(bbi_pkg::BP_W + 1 - bbi_pkg::STEP_W)'(0), slo_r};
    end
  end

  assign lin_sum = prod_r + {(bbi_pkg::BP_W + 1 - bbi_pkg::WT_W)'(0), wu}
                          * {(bbi_pkg::BP_W + 1 - bbi_pkg::STEP_W)'(0), shi_r};

  // nearest: upper entry wins when the lower weight is at most one half
  assign gap2      = {bhi_r - x_r, 1'b0};
  assign pick_hi   = gap2 <= {1'b0, dx};
  assign pick_idx  = pick_hi ? hi_r : lo_r;
  assign pick_step = pick_hi ? shi_r : slo_r;

  always_comb begin
    status_nxt = bbi_pkg::ST_OK;
    lower_nxt  = '0;
    upper_nxt  = '0;
    wl_nxt     = '0;
    wu_nxt     = '0;
    drv_nxt    = '0;
    val_nxt    = '0;
    case (cmd.res_sel)
      bbi_pkg::RES_WRITE: begin
        status_nxt = bbi_pkg::ST_WRITE;
      end
      bbi_pkg::RES_CLAMP_HI: begin
        lower_nxt = kend;
        upper_nxt = kend;
        wl_nxt    = bbi_pkg::WEIGHT_ONE;
        drv_nxt   = {1'b0, kend} + bbi_pkg::CNT_W'(1);
        val_nxt   = {rd_st_r, bbi_pkg::FRAC_W'(0)};
      end
      bbi_pkg::RES_CLAMP_LO: begin
        wl_nxt  = bbi_pkg::WEIGHT_ONE;
        drv_nxt = bbi_pkg::CNT_W'(1);
        val_nxt = {rd_st_r, bbi_pkg::FRAC_W'(0)};
      end
      bbi_pkg::RES_EQUAL: begin
        status_nxt = bbi_pkg::ST_EQUAL;
      end
      bbi_pkg::RES_NEAREST: begin
        lower_nxt = pick_idx;
        wl_nxt    = bbi_pkg::WEIGHT_ONE;
        drv_nxt   = {1'b0, pick_idx} + bbi_pkg::CNT_W'(1);
        val_nxt   = {pick_step, bbi_pkg::FRAC_W'(0)};
      end
      bbi_pkg::RES_LINEAR: begin
        lower_nxt = lo_r;
        upper_nxt = hi_r;
        wl_nxt    = wl;
        wu_nxt    = wu;
        drv_nxt   = {1'b0, lo_r} + bbi_pkg::CNT_W'(1);
        val_nxt   = lin_sum[bbi_pkg::VAL_W-1:0];
      end
      bbi_pkg::RES_MODE: begin
        status_nxt = bbi_pkg::ST_MODE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_sel != bbi_pkg::RES_HOLD) begin
      out_status       <= status_nxt;
      out_lower_index  <= lower_nxt;
      out_upper_index  <= upper_nxt;
      out_weight_lower <= wl_nxt;
      out_weight_upper <= wu_nxt;
      out_driver_step  <= drv_nxt;
      out_interp_step  <= val_nxt;
    end
  end

  always_comb begin
    stat.clamp_hi  = (x_r > rd_bp_r) || (kend == '0);
    stat.clamp_lo  = x_r < rd_bp_r;
    stat.more      = span > bbi_pkg::IDX_W'(1);
    stat.dx_zero   = dx == '0;
    stat.mode_near = mode_r == bbi_pkg::MODE_NEAREST;
    stat.mode_lin  = mode_r == bbi_pkg::MODE_LINEAR;
  end

endmodule
`default_nettype wire

@@ rtl/core/bbi_ctrl.sv @@
`default_nettype none
module bbi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_cmd,
  input  wire bbi_pkg::bbi_stat_t  stat,
  output bbi_pkg::bbi_cmd_t        cmd,
  output logic                     busy,
  output logic                     out_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RDK  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_CHK0 = 4'd4;
  localparam logic [3:0] S_BIS  = 4'd5;
  localparam logic [3:0] S_EVAL = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_LIN  = 4'd9;

  logic [3:0]                      state_r, state_nxt;
  logic [bbi_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_cmd == bbi_pkg::CMD_WRITE) ? S_WR : S_RDK;
        end
      end
      S_WR: begin
        cmd.mem_wr  = 1'b1;
        cmd.res_sel = bbi_pkg::RES_WRITE;
        state_nxt   = S_IDLE;
      end
      S_RDK: begin
        cmd.rd_sel = bbi_pkg::RD_KEND;
        state_nxt  = S_RD0;
      end
      S_RD0: begin
        if (stat.clamp_hi) begin
          cmd.res_sel = bbi_pkg::RES_CLAMP_HI;
          state_nxt   = S_IDLE;
        end else begin
          cmd.load_hi = 1'b1;
          cmd.rd_sel  = bbi_pkg::RD_ZERO;
          state_nxt   = S_CHK0;
        end
      end
      S_CHK0: begin
        if (stat.clamp_lo) begin
          cmd.res_sel = bbi_pkg::RES_CLAMP_LO;
          state_nxt   = S_IDLE;
        end else begin
          cmd.load_lo = 1'b1;
          if (stat.more) begin
            cmd.rd_sel = bbi_pkg::RD_MID;
            state_nxt  = S_BIS;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_BIS: begin
        cmd.bis_step = 1'b1;
        if (stat.more) begin
          cmd.rd_sel = bbi_pkg::RD_MID;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.dx_zero) begin
          cmd.res_sel = bbi_pkg::RES_EQUAL;
          state_nxt   = S_IDLE;
        end else if (stat.mode_near) begin
          cmd.res_sel = bbi_pkg::RES_NEAREST;
          state_nxt   = S_IDLE;
        end else if (stat.mode_lin) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.res_sel = bbi_pkg::RES_MODE;
          state_nxt   = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == bbi_pkg::DIV_CNT_W'(bbi_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + bbi_pkg::DIV_CNT_W'(1);
        end
      end
      S_MUL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_LIN;
      end
      S_LIN: begin
        cmd.res_sel = bbi_pkg::RES_LINEAR;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= cmd.res_sel != bbi_pkg::RES_HOLD;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_write_path: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == bbi_pkg::CMD_WRITE) |=> state_r == S_WR)
    else $error("write transaction did not enter the write state");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_sel != bbi_pkg::RES_HOLD) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result load not followed by strobe and idle");

  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result strobe without an item in flight");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> cnt_r < bbi_pkg::DIV_CNT_W'(bbi_pkg::DIV_STEPS))
    else $error("divider step count out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/core/breakpoint_bisect_interpolator.sv @@
`default_nettype none
// Breakpoint table interpolator.
// Input: an item is taken when start is high and busy is low. in_cmd selects
// a table write (in_entry_index, in_entry_breakpoint, in_entry_step) or a query
// (in_sample_point). Exactly one result follows each item, shown for a single
// cycle with out_valid high; the receiver cannot stall it.
// Configuration: cfg_we with cfg_index 0 sets the interpolation mode, index 1
// the number of entries in use. Write only while busy is low.
// From accept to out_valid: a write stores its entry. A query reads the
// last and first entries, then runs one table probe per cycle in the
// bisection (up to log2 of the table depth); a clamped query ends after the
// end checks, nearest or error after the bisection, and linear adds a serial
// divider and a multiply step. The single table read port and the divider set
// the length of a query; one item is in flight at a time, and a new one
// may be taken in the cycle its result strobe is up.
// Reset: mode returns to linear and entries in use to one; the table is not
// cleared, and entries must be written before a query reads them.
module breakpoint_bisect_interpolator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_cmd,
  input  wire logic [bbi_pkg::IDX_W-1:0]      in_entry_index,
  input  wire logic [bbi_pkg::BP_W-1:0]       in_entry_breakpoint,
  input  wire logic [bbi_pkg::STEP_W-1:0]     in_entry_step,
  input  wire logic [bbi_pkg::BP_W-1:0]       in_sample_point,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [bbi_pkg::IDX_W-1:0]           out_lower_index,
  output logic [bbi_pkg::IDX_W-1:0]           out_upper_index,
  output logic [bbi_pkg::WT_W-1:0]            out_weight_lower,
  output logic [bbi_pkg::WT_W-1:0]            out_weight_upper,
  output logic [bbi_pkg::CNT_W-1:0]           out_driver_step,
  output logic [bbi_pkg::VAL_W-1:0]           out_interp_step,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [bbi_pkg::CFG_W-1:0]      cfg_wdata
);

  bbi_pkg::bbi_cmd_t  cmd;
  bbi_pkg::bbi_stat_t stat;

  bbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bbi_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_entry_index      (in_entry_index),
    .in_entry_breakpoint (in_entry_breakpoint),
    .in_entry_step       (in_entry_step),
    .in_sample_point     (in_sample_point),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .cmd                 (cmd),
    .stat                (stat),
    .out_status          (out_status),
    .out_lower_index     (out_lower_index),
    .out_upper_index     (out_upper_index),
    .out_weight_lower    (out_weight_lower),
    .out_weight_upper    (out_weight_upper),
    .out_driver_step     (out_driver_step),
    .out_interp_step     (out_interp_step)
  );

endmodule
`default_nettype wire
